/* hdl/tun_pkg.sv */
// Shared types for the triangle unit normal pipeline.
// Used by the square root cells, the divide cells and the top level.
package tun_pkg;

  localparam int MagW   = 31;
  localparam int SqSteps = 32;
  localparam int QBits  = 15;
  localparam int RemW   = 46;

  typedef struct packed {
    logic                      valid;
    logic                      degen;
    logic [2:0]                neg;
    logic [2:0][MagW-1:0]      mag;
    logic [63:0]               x;
    logic [63:0]               res;
  } tun_sqrt_t;

  typedef struct packed {
    logic                      valid;
    logic                      degen;
    logic [2:0]                neg;
    logic [31:0]               len;
    logic [2:0][RemW-1:0]      rem;
    logic [2:0][QBits-1:0]     quo;
  } tun_div_t;

endpackage

/* hdl/tun_sqrt_cell.sv */
// One digit step of the integer square root, registered.
// Depends on tun_pkg.
module tun_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  tun_pkg::tun_sqrt_t d,
  output tun_pkg::tun_sqrt_t q
);
  import tun_pkg::*;

  localparam logic [63:0] Bit = 64'(1) << (62 - 2 * STEP);

  tun_sqrt_t q_next;
  logic [63:0] trial;

  always_comb begin
    q_next = d;
    trial  = d.res + Bit;
    if (d.x >= trial) begin
      q_next.x   = d.x - trial;
      q_next.res = (d.res >> 1) + Bit;
    end else begin
      q_next.res = d.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end
endmodule

/* hdl/tun_div_cell.sv */
// One quotient bit of the three restoring divisions, registered.
// Depends on tun_pkg.
module tun_div_cell #(
  parameter int K = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  tun_pkg::tun_div_t d,
  output tun_pkg::tun_div_t q
);
  import tun_pkg::*;

  tun_div_t q_next;
  logic [RemW-1:0] dv;

  always_comb begin
    q_next = d;
    dv = {{(RemW-32){1'b0}}, d.len} << K;
    for (int i = 0; i < 3; i++) begin
      if (d.rem[i] >= dv) begin
        q_next.rem[i]    = d.rem[i] - dv;
        q_next.quo[i][K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end
endmodule

/* hdl/triangle_unit_normal.sv */
// Triangle unit normal: a fully pipelined unit that accepts one triangle per cycle while
// the output is not stalled and returns its unit facet normal. The pipe is the square root
// chain, the divide chain and the edge, product, scale and output registers; a stalled
// output freezes the whole pipe. Depends on tun_pkg.
module triangle_unit_normal (
  input  logic               clk,
  input  logic               rst,
  input  logic               tri_valid,
  output logic               tri_stall,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] az,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by,
  input  logic signed [31:0] bz,
  input  logic signed [31:0] cx,
  input  logic signed [31:0] cy,
  input  logic signed [31:0] cz,
  output logic               norm_valid,
  input  logic               norm_stall,
  output logic signed [15:0] nx,
  output logic signed [15:0] ny,
  output logic signed [15:0] nz,
  output logic               degenerate
);
  import tun_pkg::*;

  logic en;
  assign en = !(norm_valid && norm_stall);
  assign tri_stall = !en;

  // edges: 0..2 = B-A, 3..5 = C-A
  logic [9:1] v;
  logic signed [5:0][32:0] e;
  logic [5:0][31:0] ea;
  logic [5:0] en_neg;
  logic [5:0][63:0] p;
  logic [5:0] pn;
  logic signed [5:0][64:0] ps;
  logic signed [2:0][65:0] w;
  logic [2:0][64:0] wm;
  logic [2:0] wn;
  logic dg6, dg7, dg8;
  logic [2:0] n7, n8, n9;
  logic [2:0][64:0] m7;
  logic [6:0] s7;
  logic [2:0][MagW-1:0] m8, m9;
  logic [2:0][63:0] sq9;
  logic [64:0] orv;
  logic [6:0] blen;

  always_comb begin
    orv = wm[0] | wm[1] | wm[2];
    blen = '0;
    for (int i = 0; i < 65; i++) begin
      if (orv[i]) begin
        blen = 7'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[8:1], tri_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e[0] <= 33'(bx) - 33'(ax);
      e[1] <= 33'(by) - 33'(ay);
      e[2] <= 33'(bz) - 33'(az);
      e[3] <= 33'(cx) - 33'(ax);
      e[4] <= 33'(cy) - 33'(ay);
      e[5] <= 33'(cz) - 33'(az);
      for (int i = 0; i < 6; i++) begin
        en_neg[i] <= e[i][32];
        ea[i] <= e[i][32] ? 32'(-e[i]) : e[i][31:0];
      end
      // x: e1y*e2z - e1z*e2y ; y: e1z*e2x - e1x*e2z ; z: e1x*e2y - e1y*e2x
      p[0] <= ea[1] * ea[5];  pn[0] <= en_neg[1] ^ en_neg[5];
      p[1] <= ea[2] * ea[4];  pn[1] <= en_neg[2] ^ en_neg[4];
      p[2] <= ea[2] * ea[3];  pn[2] <= en_neg[2] ^ en_neg[3];
      p[3] <= ea[0] * ea[5];  pn[3] <= en_neg[0] ^ en_neg[5];
      p[4] <= ea[0] * ea[4];  pn[4] <= en_neg[0] ^ en_neg[4];
      p[5] <= ea[1] * ea[3];  pn[5] <= en_neg[1] ^ en_neg[3];
      for (int i = 0; i < 6; i++) begin
        ps[i] <= pn[i] ? -$signed({1'b0, p[i]}) : $signed({1'b0, p[i]});
      end
      for (int i = 0; i < 3; i++) begin
        w[i] <= 66'($signed(ps[2*i])) - 66'($signed(ps[2*i+1]));
        wn[i] <= w[i][65];
        wm[i] <= w[i][65] ? 65'(-w[i]) : w[i][64:0];
      end
      dg6 <= (orv == '0);
      m7 <= wm;
      n7 <= wn;
      s7 <= (blen > 7'd31) ? blen - 7'd31 : 7'd0;
      dg7 <= dg6;
      for (int i = 0; i < 3; i++) begin
        m8[i] <= MagW'(m7[i] >> s7);
      end
      n8 <= n7;
      dg8 <= dg7;
      for (int i = 0; i < 3; i++) begin
        sq9[i] <= {33'b0, m8[i]} * {33'b0, m8[i]};
      end
      m9 <= m8;
      n9 <= n8;
    end
  end

  tun_sqrt_t sq [0:SqSteps];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].valid <= 1'b0;
    end else if (en) begin
      sq[0].valid <= v[9];
      sq[0].degen <= dg8;
      sq[0].neg   <= n9;
      sq[0].mag   <= m9;
      sq[0].x     <= sq9[0] + sq9[1] + sq9[2];
      sq[0].res   <= '0;
    end
  end

  for (genvar g = 0; g < SqSteps; g++) begin : g_sqrt
    tun_sqrt_cell #(.STEP(g)) u_cell (
      .clk(clk), .rst(rst), .en(en), .d(sq[g]), .q(sq[g+1])
    );
  end

  tun_div_t dv [0:QBits];
  tun_sqrt_t sl;

  always_comb begin
    sl = sq[SqSteps];
    dv[0].valid = sl.valid;
    dv[0].degen = sl.degen;
    dv[0].neg   = sl.neg;
    dv[0].len   = (sl.res[31:0] == '0) ? 32'd1 : sl.res[31:0];
    dv[0].quo   = '0;
    for (int i = 0; i < 3; i++) begin
      dv[0].rem[i] = {1'b0, sl.mag[i], 14'b0};
    end
  end

  for (genvar g = 0; g < QBits; g++) begin : g_div
    tun_div_cell #(.K(QBits - 1 - g)) u_cell (
      .clk(clk), .rst(rst), .en(en), .d(dv[g]), .q(dv[g+1])
    );
  end

  tun_div_t dl;
  assign dl = dv[QBits];

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_valid <= 1'b0;
    end else if (en) begin
      norm_valid <= dl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx <= dl.neg[0] ? -$signed({1'b0, dl.quo[0]}) : $signed({1'b0, dl.quo[0]});
      ny <= dl.neg[1] ? -$signed({1'b0, dl.quo[1]}) : $signed({1'b0, dl.quo[1]});
      nz <= dl.neg[2] ? -$signed({1'b0, dl.quo[2]}) : $signed({1'b0, dl.quo[2]});
      degenerate <= dl.degen;
    end
  end
endmodule

/* tb/sv/tb_triangle_unit_normal.sv */
// Testbench for triangle_unit_normal: directed table of triangles, then random
// triangles, each normal checked against an internal predictor.
// Depends on the triangle_unit_normal RTL only.
module tb_triangle_unit_normal;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 57;
  localparam int WatchLimit = 20000;
  localparam logic signed [31:0] MaxC = 32'sh7fffffff;
  localparam logic signed [31:0] MinC = 32'sh80000000;

  typedef struct {
    logic signed [31:0] v [9];
  } tri_t;

  typedef struct packed {
    logic signed [15:0] x, y, z;
    logic               degen;
  } normal_t;

  typedef struct {
    tri_t    t;
    logic    known;
    normal_t n;
  } row_t;

  logic clk = 0, rst = 1;
  logic tri_valid = 0, tri_stall;
  logic signed [31:0] ax = 0, ay = 0, az = 0, bx = 0, by = 0, bz = 0, cx = 0, cy = 0, cz = 0;
  logic norm_valid, norm_stall = 0;
  logic signed [15:0] nx, ny, nz;
  logic degenerate;

  normal_t expected_normals[$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  sink_wait = 0;
  bit  stim_done = 0;
  bit  hold_sink = 0;
  bit  sink_held = 0;

  always #2 clk = ~clk;

  triangle_unit_normal u_dut (.*);

  function automatic normal_t facet_normal(tri_t t);
    logic signed [66:0] e1x, e1y, e1z, e2x, e2y, e2z, cr[3];
    logic [64:0] mag[3], m_or;
    logic [63:0] sm[3], sum, len, rest, bit_v, q;
    normal_t r;
    int l, s;
    e1x = t.v[3] - t.v[0]; e1y = t.v[4] - t.v[1]; e1z = t.v[5] - t.v[2];
    e2x = t.v[6] - t.v[0]; e2y = t.v[7] - t.v[1]; e2z = t.v[8] - t.v[2];
    cr[0] = e1y * e2z - e1z * e2y;
    cr[1] = e1z * e2x - e1x * e2z;
    cr[2] = e1x * e2y - e1y * e2x;
    m_or = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? 65'(-cr[i]) : 65'(cr[i]);
      m_or |= mag[i];
    end
    r = '{0, 0, 0, 1'b1};
    if (m_or == 0) return r;
    r.degen = 0;
    l = 0;
    for (int i = 0; i < 65; i++) if (m_or[i]) l = i + 1;
    s = l > 31 ? l - 31 : 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      sm[i] = 64'((mag[i] >> s) & 65'h7fffffff);
      sum += sm[i] * sm[i];
    end
    rest = sum; len = 0; bit_v = 64'd1 << 62;
    while (bit_v > rest) bit_v >>= 2;
    while (bit_v != 0) begin
      if (rest >= len + bit_v) begin
        rest -= len + bit_v;
        len = (len >> 1) + bit_v;
      end else len >>= 1;
      bit_v >>= 2;
    end
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = (sm[i] << 14) / len;
      if (cr[i] < 0) q = -q;
      if (i == 0) r.x = q[15:0];
      else if (i == 1) r.y = q[15:0];
      else r.z = q[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? MaxC : MinC;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      2: return 32'($signed($urandom_range(0, 40)) - 20) <<< $urandom_range(0, 26);
      default: return $urandom;
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    int k;
    for (int i = 0; i < 9; i++) t.v[i] = rand_coord();
    case ($urandom_range(0, 9))
      0: for (int i = 0; i < 3; i++) t.v[3 + i] = t.v[i];
      1: begin
        k = $urandom_range(-3, 3);
        for (int i = 0; i < 3; i++) t.v[6 + i] = t.v[i] + k * (t.v[3 + i] - t.v[i]);
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic int gap_len();
    return $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3)
                                                                   : $urandom_range(10, 60));
  endfunction

  task automatic send(tri_t t);
    {ax, ay, az, bx, by, bz, cx, cy, cz} <=
      {t.v[0], t.v[1], t.v[2], t.v[3], t.v[4], t.v[5], t.v[6], t.v[7], t.v[8]};
    tri_valid <= 1;
    do @(posedge clk); while (tri_stall);
    expected_normals = {expected_normals, facet_normal(t)};
  endtask

  task automatic send_gapped(tri_t t);
    int g;
    send(t);
    if ($urandom_range(0, 3) == 0) begin
      g = gap_len();
      if (g > 0) begin
        tri_valid <= 0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  function automatic tri_t mk(logic signed [31:0] a0, a1, a2, b0, b1, b2,
                              c0, c1, c2);
    tri_t t;
    t.v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    return t;
  endfunction

  // rows with known result are cross-checked against the predictor as well
  row_t directed[$];

  function automatic void add_row(row_t r);
    directed = {directed, r};
  endfunction

  initial begin
    add_row('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 1}});
    add_row('{mk(5, 5, 5, 5, 5, 5, 7, 1, 9), 1, '{0, 0, 0, 1}});
    add_row('{mk(0, 0, 0, 1, 2, 3, 2, 4, 6), 1, '{0, 0, 0, 1}});
    add_row('{mk(0, 0, 0, 65536, 0, 0, 0, 65536, 0), 1, '{0, 0, 16384, 0}});
    add_row('{mk(0, 0, 0, 0, 65536, 0, 0, 0, 65536), 1, '{16384, 0, 0, 0}});
    add_row('{mk(0, 0, 0, 0, 0, 65536, 65536, 0, 0), 1, '{0, 16384, 0, 0}});
    add_row('{mk(0, 0, 0, 0, 65536, 0, 65536, 0, 0), 1, '{0, 0, -16384, 0}});
    add_row('{mk(MinC, MinC, MinC, MaxC, MinC, MinC, MinC, MaxC, MinC), 1,
              '{0, 0, 16384, 0}});
    add_row('{mk(MaxC, MaxC, MaxC, MinC, MaxC, MaxC, MaxC, MinC, MaxC), 1,
              '{0, 0, 16384, 0}});
    add_row('{mk(MinC, MinC, MinC, MaxC, MaxC, MaxC, MinC, MaxC, MaxC), 0, '{0, 0, 0, 0}});
    add_row('{mk(MaxC, MinC, MaxC, MinC, MaxC, MinC, MinC, MinC, MaxC), 0, '{0, 0, 0, 0}});
    add_row('{mk(MinC, MaxC, MinC, MaxC, MinC, MaxC, MaxC, MaxC, MinC), 0, '{0, 0, 0, 0}});
    add_row('{mk(-1, -1, -1, 0, 0, 0, 1, 2, 4), 0, '{0, 0, 0, 0}});
    add_row('{mk(0, 0, 0, 1, 0, 0, 0, 1, 1), 0, '{0, 0, 0, 0}});
    add_row('{mk(100, -7, 3, -55, 12, 999, 4, 4, -4), 0, '{0, 0, 0, 0}});
    add_row('{mk(MaxC, 0, 0, 0, MaxC, 0, 0, 0, MaxC), 0, '{0, 0, 0, 0}});
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[i]) begin
      if (directed[i].known && facet_normal(directed[i].t) != directed[i].n) begin
        $error("directed row %0d: predictor disagrees with table", i);
        errors++;
      end
      send_gapped(directed[i].t);
    end
    for (int i = 0; i < 800; i++) begin
      if (i == 300) hold_sink = 1;
      if (i == 420 || i == 650) begin
        tri_valid <= 0;
        wait (expected_normals.size() == 0);
        @(posedge clk);
      end
      if (i >= 300 && i < 420) send(rand_tri());
      else send_gapped(rand_tri());
    end
    tri_valid <= 0;
    stim_done = 1;
  end

  always @(posedge clk) begin
    if (rst) norm_stall <= 0;
    else if (hold_sink && !sink_held) begin
      norm_stall <= 1;
      sink_held = 1;
      fork
        begin
          repeat (300) @(posedge clk);
          hold_sink = 0;
        end
      join_none
    end else if (sink_held && hold_sink) norm_stall <= 1;
    else if (sink_wait > 0) begin
      norm_stall <= 1;
      sink_wait--;
    end else if ($urandom_range(0, 199) == 0) begin
      norm_stall <= 1;
      sink_wait = $urandom_range(10, 60);
    end else norm_stall <= ($urandom_range(0, 9) < 3);
  end

  always @(posedge clk) begin
    normal_t e;
    if (!rst && norm_valid && !norm_stall) begin
      if (expected_normals.size() == 0) begin
        $error("normal with no triangle pending");
        errors++;
      end else begin
        e = expected_normals.pop_front();
        if (nx !== e.x) begin $error("nx expected %0d got %0d", e.x, nx); errors++; end
        if (ny !== e.y) begin $error("ny expected %0d got %0d", e.y, ny); errors++; end
        if (nz !== e.z) begin $error("nz expected %0d got %0d", e.z, nz); errors++; end
        if (degenerate !== e.degen) begin
          $error("degenerate expected %0d got %0d", e.degen, degenerate);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((tri_valid && !tri_stall) || (norm_valid && !norm_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (expected_normals.size() == 0);
    repeat (Latency + 20) @(posedge clk);
    if (errors == 0 && expected_normals.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

/* sim.f */
hdl/tun_pkg.sv
hdl/tun_sqrt_cell.sv
hdl/tun_div_cell.sv
hdl/triangle_unit_normal.sv
tb/sv/tb_triangle_unit_normal.sv
